// ----- hdl/stq_pkg.sv -----
package stq_pkg;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_ARM   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  // result kinds
  typedef enum logic [2:0] {
    RK_EXPIRED = 3'd0,
    RK_NONE    = 3'd1,
    RK_ARMED   = 3'd2,
    RK_REFUSED = 3'd3,
    RK_QUERY   = 3'd4
  } rkind_e;

  // back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_REBASE,
    ST_INSERT
  } state_e;

  localparam int unsigned FIFO_DEPTH = 2;

  // classified command from the front end
  typedef struct packed {
    kind_e       kind;
    logic        slot_ok;
    logic [3:0]  slot;
    logic [31:0] delay;
    logic [7:0]  owner;
    logic        cb;
    logic [31:0] qv;
  } cmd_t;

  // one result item
  typedef struct packed {
    rkind_e     kind;
    logic [3:0] slot;
    logic [7:0] owner;
    logic       wake;
    logic       sw;
    logic       reached;
    logic       last;
  } res_t;

endpackage

// ----- hdl/stq_front.sv -----
module stq_front import stq_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [79:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        fifo_full_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic [11:0] slot_ext;

  // unpack and classify
  always_comb begin
    cmd_o.kind  = kind_e'(s_tuser_i);
    cmd_o.slot  = s_tdata_i[3:0];
    cmd_o.delay = s_tdata_i[35:4];
    cmd_o.owner = s_tdata_i[43:36];
    cmd_o.cb    = s_tdata_i[44];
    cmd_o.qv    = s_tdata_i[76:45];
    slot_ext    = {8'b0, s_tdata_i[3:0]};
    cmd_o.slot_ok = (slot_ext < 12'(NUM_TIMERS));
  end

  // a no-op transfer is taken and dropped
  assign s_tready_o = !fifo_full_i;
  assign push_o     = s_tvalid_i && !fifo_full_i && (cmd_o.kind != KIND_NOP);

endmodule

// ----- hdl/stq_fifo.sv -----
module stq_fifo import stq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  cmd_t          mem_q [FIFO_DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // pointer and fill updates
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/stq_back.sv -----
module stq_back import stq_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 16,
  parameter int unsigned OWNER_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic empty_i,
  input  cmd_t cmd_i,
  output logic pop_o,
  output logic m_valid_o,
  input  logic m_ready_i,
  output res_t res_o
);

  localparam int unsigned N  = NUM_TIMERS;
  localparam int unsigned SW = (N > 1) ? $clog2(N) : 1;

  // sorted cell row, cell 0 holds the earliest deadline
  logic [N-1:0]          valid_q, valid_d;
  logic [31:0]           dl_q   [N];
  logic [31:0]           dl_d   [N];
  logic [SW-1:0]         cs_q   [N];
  logic [SW-1:0]         cs_d   [N];
  logic [OWNER_BITS-1:0] co_q   [N];
  logic [OWNER_BITS-1:0] co_d   [N];
  logic [N-1:0]          cb_q, cb_d;
  logic [N-1:0]          less;

  logic [N-1:0]          busy_q, busy_d;
  logic [31:0]           cnt_q, cnt_d;
  state_e                state_q, state_d;

  // latched arm request
  logic [31:0]           ndl_q, ndl_d;
  logic [SW-1:0]         aslot_q, aslot_d;
  logic [OWNER_BITS-1:0] aown_q, aown_d;
  logic                  acb_q, acb_d;

  logic                  ovalid_q, ovalid_d;
  res_t                  out_q, res_d;

  logic                  can_emit, emit;
  logic                  pop_head, do_rebase, do_insert;
  logic                  hd_exp, nx_exp, refused, full;
  logic [11:0]           slot_ext;
  logic [SW-1:0]         cmd_idx;
  logic [32:0]           sum;
  logic [39:0]           own_ext;
  logic [OWNER_BITS+7:0] hd_own_ext;
  logic [SW+3:0]         hd_slot_ext, a_slot_ext;

  assign can_emit = !ovalid_q || m_ready_i;
  assign full     = valid_q[N-1];
  assign hd_exp   = valid_q[0] && (dl_q[0] <= cnt_q);
  assign nx_exp   = valid_q[1] && (dl_q[1] <= cnt_q);

  // width adaptation of slot and owner fields
  assign slot_ext    = {8'b0, cmd_i.slot};
  assign cmd_idx     = slot_ext[SW-1:0];
  assign own_ext     = {32'b0, cmd_i.owner};
  assign hd_own_ext  = {8'b0, co_q[0]};
  assign hd_slot_ext = {4'b0, cs_q[0]};
  assign a_slot_ext  = {4'b0, aslot_q};
  assign sum         = {1'b0, cnt_q} + {1'b0, cmd_i.delay};
  assign refused     = !cmd_i.slot_ok || busy_q[cmd_idx] || full;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i && can_emit) begin
          if (cmd_i.kind == KIND_TICK) begin
            state_d = ST_TICK;
          end else if (cmd_i.kind == KIND_ARM && !refused) begin
            state_d = sum[32] ? ST_REBASE : ST_INSERT;
          end
        end
      end
      ST_TICK: begin
        if (can_emit && !(hd_exp && nx_exp)) begin
          state_d = ST_IDLE;
        end
      end
      ST_REBASE: state_d = ST_INSERT;
      ST_INSERT: begin
        if (can_emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop_o     = 1'b0;
    emit      = 1'b0;
    pop_head  = 1'b0;
    do_rebase = 1'b0;
    do_insert = 1'b0;
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    ndl_d     = ndl_q;
    aslot_d   = aslot_q;
    aown_d    = aown_q;
    acb_d     = acb_q;
    res_d     = '0;
    res_d.last = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i && can_emit) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            KIND_TICK: cnt_d = cnt_q + 32'd1;
            KIND_ARM: begin
              if (refused) begin
                emit       = 1'b1;
                res_d.kind = RK_REFUSED;
                res_d.slot = cmd_i.slot;
              end else begin
                aslot_d = cmd_idx;
                aown_d  = own_ext[OWNER_BITS-1:0];
                acb_d   = cmd_i.cb;
                ndl_d   = sum[32] ? cmd_i.delay : sum[31:0];
              end
            end
            KIND_QUERY: begin
              emit          = 1'b1;
              res_d.kind    = RK_QUERY;
              res_d.reached = (cmd_i.qv <= cnt_q);
            end
            default: ;
          endcase
        end
      end
      ST_TICK: begin
        if (can_emit) begin
          emit     = 1'b1;
          res_d.sw = cnt_q[0];
          if (hd_exp) begin
            pop_head   = 1'b1;
            busy_d[cs_q[0]] = 1'b0;
            res_d.kind  = RK_EXPIRED;
            res_d.slot  = hd_slot_ext[3:0];
            res_d.owner = hd_own_ext[7:0];
            res_d.wake  = !cb_q[0];
            res_d.last  = !nx_exp;
          end else begin
            res_d.kind = RK_NONE;
          end
        end
      end
      ST_REBASE: begin
        do_rebase = 1'b1;
        cnt_d     = '0;
      end
      ST_INSERT: begin
        if (can_emit) begin
          do_insert       = 1'b1;
          busy_d[aslot_q] = 1'b1;
          emit            = 1'b1;
          res_d.kind      = RK_ARMED;
          res_d.slot      = a_slot_ext[3:0];
        end
      end
      default: ;
    endcase
  end

  // per-cell update: pop shifts down, rebase subtracts the count, insert shifts up behind the new deadline's position
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic prev_less;
    assign less[i] = valid_q[i] && (dl_q[i] < ndl_q);
    if (i == 0) begin : g_first
      assign prev_less = 1'b1;
    end else begin : g_rest
      assign prev_less = less[i-1];
    end
    always_comb begin
      valid_d[i] = valid_q[i];
      dl_d[i]    = dl_q[i];
      cs_d[i]    = cs_q[i];
      co_d[i]    = co_q[i];
      cb_d[i]    = cb_q[i];
      if (pop_head) begin
        if (i == N - 1) begin
          valid_d[i] = 1'b0;
        end else begin
          valid_d[i] = valid_q[(i+1)%N];
          dl_d[i]    = dl_q[(i+1)%N];
          cs_d[i]    = cs_q[(i+1)%N];
          co_d[i]    = co_q[(i+1)%N];
          cb_d[i]    = cb_q[(i+1)%N];
        end
      end else if (do_rebase) begin
        dl_d[i] = dl_q[i] - cnt_q;
      end else if (do_insert && !less[i]) begin
        if (prev_less) begin
          valid_d[i] = 1'b1;
          dl_d[i]    = ndl_q;
          cs_d[i]    = aslot_q;
          co_d[i]    = aown_q;
          cb_d[i]    = acb_q;
        end else begin
          valid_d[i] = valid_q[(i+N-1)%N];
          dl_d[i]    = dl_q[(i+N-1)%N];
          cs_d[i]    = cs_q[(i+N-1)%N];
          co_d[i]    = co_q[(i+N-1)%N];
          cb_d[i]    = cb_q[(i+N-1)%N];
        end
      end
    end
  end

  assign ovalid_d = emit ? 1'b1 : (m_ready_i ? 1'b0 : ovalid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      busy_q   <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      busy_q   <= busy_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q    <= dl_d;
    cs_q    <= cs_d;
    co_q    <= co_d;
    cb_q    <= cb_d;
    ndl_q   <= ndl_d;
    aslot_q <= aslot_d;
    aown_q  <= aown_d;
    acb_q   <= acb_d;
    if (emit) begin
      out_q <= res_d;
    end
  end

  assign m_valid_o = ovalid_q;
  assign res_o     = out_q;

  // busy flags and list entries stay in step
  a_busy_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(busy_q) == $countones(valid_q))
    else $error("busy flags disagree with list occupancy");

  // an insert never starts on a full list
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INSERT |-> !full)
    else $error("insert into full list");

  // a final result returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && res_d.last && state_q != ST_IDLE) |=> state_q == ST_IDLE)
    else $error("sequencer not idle after final result");

  // rebase always leads to insert
  a_rebase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REBASE |=> (state_q == ST_INSERT && cnt_q == '0))
    else $error("rebase not followed by insert");

endmodule

// ----- hdl/sorted_timer_queue.sv -----
// A query or refused arm has its result registered when the sequencer pops it.
// A tick emits one result per expired timer (or one "none") from ST_TICK.
// An arm goes from ST_IDLE to ST_INSERT, passing ST_REBASE when the deadline
// wraps and the list is rebased. A 2-entry command queue decouples input from the
// list sequencer; throughput is set by the sequencer, which handles one command at
// a time. Reset clears the count, all slots and the queue; no clearing pass is needed.
module sorted_timer_queue import stq_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 16,
  parameter int unsigned OWNER_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // slot[3:0], delay[35:4], owner_tag[43:36], has_callback[44], query_value[76:45]
  input  logic [79:0] s_axis_tdata_i,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // expired_slot[3:0], expired_owner[11:4], wake_task[12], switch_due[13], reached[14]
  output logic [15:0] m_axis_tdata_o,
  // result_kind[2:0]
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  logic push, full, pop, empty;
  cmd_t cmd_in, cmd_out;
  res_t res;

  stq_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .fifo_full_i (full),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  stq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (cmd_out)
  );

  stq_back #(.NUM_TIMERS(NUM_TIMERS), .OWNER_BITS(OWNER_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .cmd_i     (cmd_out),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .res_o     (res)
  );

  // result packing
  assign m_axis_tdata_o = {1'b0, res.reached, res.sw, res.wake, res.owner, res.slot};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

endmodule

// ----- tb/sv/sorted_timer_queue_tb.sv -----
module sorted_timer_queue_tb;
  import stq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NT = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  slot;
    logic [31:0] delay;
    logic [7:0]  owner;
    logic        cb;
    logic [31:0] qv;
  } cmd_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [79:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  sorted_timer_queue u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // timer state mirror
  logic [31:0] count_q;
  logic        busy_q   [NT];
  logic [31:0] dline_q  [NT];
  logic [7:0]  owner_q  [NT];
  logic        cb_q     [NT];
  logic [3:0]  order_q  [$];

  cmd_item_t cmd_pending[$];
  res_t      res_expected[$];

  int  mismatches = 0;
  int  cycles = 0;
  int  src_idle_pct;
  int  snk_idle_pct;
  int  hold_off_cycles;
  bit  hold_off_req;
  bit  hold_off_done;
  bit  stim_done;

  // predict the results of one accepted transfer
  task automatic predict_timer_op(input cmd_item_t c);
    res_t r;
    int   n;
    int   pos;
    logic [31:0] dl;
    logic [3:0]  s;
    r = '0;
    case (c.kind)
      KIND_TICK: begin
        count_q = count_q + 32'd1;
        n = 0;
        while (order_q.size() > 0 && dline_q[order_q[0]] <= count_q) begin
          s = order_q.pop_front();
          busy_q[s] = 1'b0;
          r = '0;
          r.kind = RK_EXPIRED;
          r.slot = s;
          r.owner = owner_q[s];
          r.wake = ~cb_q[s];
          r.sw = count_q[0];
          res_expected.push_back(r);
          n++;
        end
        if (n == 0) begin
          r = '0;
          r.kind = RK_NONE;
          r.sw = count_q[0];
          r.last = 1'b1;
          res_expected.push_back(r);
        end else begin
          res_expected[res_expected.size()-1].last = 1'b1;
        end
      end
      KIND_ARM: begin
        r.slot = c.slot;
        r.last = 1'b1;
        if (busy_q[c.slot] || order_q.size() >= NT) begin
          r.kind = RK_REFUSED;
        end else begin
          dl = count_q + c.delay;
          // deadline wrap: rebase the whole list to a zero count
          if (dl < c.delay) begin
            foreach (order_q[i]) dline_q[order_q[i]] -= count_q;
            count_q = '0;
            dl = c.delay;
          end
          busy_q[c.slot] = 1'b1;
          dline_q[c.slot] = dl;
          owner_q[c.slot] = c.owner;
          cb_q[c.slot] = c.cb;
          pos = 0;
          while (pos < order_q.size() && dline_q[order_q[pos]] < dl) pos++;
          order_q.insert(pos, c.slot);
          r.kind = RK_ARMED;
        end
        res_expected.push_back(r);
      end
      KIND_QUERY: begin
        r.kind = RK_QUERY;
        r.reached = (c.qv <= count_q);
        r.last = 1'b1;
        res_expected.push_back(r);
      end
      default: ;
    endcase
  endtask

  function automatic cmd_item_t mk_cmd(kind_e k, logic [3:0] s, logic [31:0] d,
                                       logic [7:0] o, logic cb, logic [31:0] q);
    cmd_item_t c;
    c.kind = k; c.slot = s; c.delay = d; c.owner = o; c.cb = cb; c.qv = q;
    return c;
  endfunction

  function automatic cmd_item_t rand_cmd();
    cmd_item_t c;
    int p;
    c.slot = 4'($urandom_range(0, 15));
    c.owner = 8'($urandom);
    c.cb = 1'($urandom);
    c.qv = $urandom;
    p = $urandom_range(0, 99);
    if (p < 4) c.qv = count_q + 32'($urandom_range(0, 3)) - 32'd1;
    p = $urandom_range(0, 99);
    if (p < 70) c.delay = 32'($urandom_range(0, 12));
    else if (p < 85) c.delay = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
    else c.delay = $urandom;
    p = $urandom_range(0, 99);
    if (p < 45) c.kind = KIND_TICK;
    else if (p < 85) c.kind = KIND_ARM;
    else if (p < 95) c.kind = KIND_QUERY;
    else c.kind = KIND_NOP;
    return c;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // stimulus
  initial begin
    int i;
    src_idle_pct = 20;
    snk_idle_pct = 58;
    hold_off_req = 1'b0;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, all kinds, busy slot, same-deadline order, wrap
    cmd_pending.push_back(mk_cmd(KIND_TICK, 4'd0, 32'd0, 8'd0, 1'b0, 32'd0));
    cmd_pending.push_back(mk_cmd(KIND_QUERY, 4'd0, 32'd0, 8'd0, 1'b0, 32'd0));
    cmd_pending.push_back(mk_cmd(KIND_QUERY, 4'd0, 32'd0, 8'd0, 1'b0, 32'd1));
    cmd_pending.push_back(mk_cmd(KIND_QUERY, 4'd0, 32'd0, 8'd0, 1'b0, 32'd2));
    cmd_pending.push_back(mk_cmd(KIND_QUERY, 4'd0, '1, 8'd0, 1'b0, '1));
    cmd_pending.push_back(mk_cmd(KIND_ARM, 4'd0, 32'd2, 8'hFF, 1'b1, '1));
    cmd_pending.push_back(mk_cmd(KIND_ARM, 4'd15, 32'd2, 8'h00, 1'b0, '0));
    cmd_pending.push_back(mk_cmd(KIND_ARM, 4'd0, 32'd5, 8'h5A, 1'b0, '0));
    cmd_pending.push_back(mk_cmd(KIND_ARM, 4'd7, 32'd0, 8'hA5, 1'b1, '0));
    cmd_pending.push_back(mk_cmd(KIND_NOP, 4'd3, '1, 8'hFF, 1'b1, '1));
    cmd_pending.push_back(mk_cmd(KIND_TICK, 4'd0, 32'd0, 8'd0, 1'b0, 32'd0));
    cmd_pending.push_back(mk_cmd(KIND_TICK, 4'd0, 32'd0, 8'd0, 1'b0, 32'd0));
    cmd_pending.push_back(mk_cmd(KIND_ARM, 4'd3, 32'd10, 8'h11, 1'b0, '0));
    cmd_pending.push_back(mk_cmd(KIND_ARM, 4'd4, '1, 8'h22, 1'b1, '0));
    cmd_pending.push_back(mk_cmd(KIND_ARM, 4'd5, 32'hFFFF_FFFE, 8'h33, 1'b0, '0));
    cmd_pending.push_back(mk_cmd(KIND_QUERY, 4'd0, 32'd0, 8'd0, 1'b0, 32'd0));
    for (i = 0; i < 12; i++)
      cmd_pending.push_back(mk_cmd(KIND_TICK, 4'd0, 32'd0, 8'd0, 1'b0, 32'd0));
    // arm slots at one deadline; 4 and 5 stay busy, so a tick drains fourteen
    for (i = 0; i < 16; i++)
      cmd_pending.push_back(mk_cmd(KIND_ARM, 4'(i), 32'd1, 8'(i * 9), 1'(i), '0));
    cmd_pending.push_back(mk_cmd(KIND_TICK, 4'd0, 32'd0, 8'd0, 1'b0, 32'd0));
    wait (cmd_pending.size() == 0);

    // sender pauses until everything has drained
    wait (res_expected.size() == 0);

    // long receiver hold-off while the sender keeps offering
    hold_off_req = 1'b1;
    for (i = 0; i < 40; i++) cmd_pending.push_back(rand_cmd());
    wait (cmd_pending.size() == 0);

    for (i = 0; i < 170; i++) cmd_pending.push_back(rand_cmd());
    wait (cmd_pending.size() == 0);
    src_idle_pct = 58;
    snk_idle_pct = 20;
    for (i = 0; i < 150; i++) cmd_pending.push_back(rand_cmd());
    wait (cmd_pending.size() == 0);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (i = 0; i < 150; i++) cmd_pending.push_back(rand_cmd());
    wait (cmd_pending.size() == 0);
    stim_done = 1'b1;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= KIND_NOP;
      count_q = '0;
      order_q.delete();
      for (int k = 0; k < NT; k++) begin
        busy_q[k] = 1'b0; dline_q[k] = '0; owner_q[k] = '0; cb_q[k] = 1'b0;
      end
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_timer_op(cmd_pending.pop_front());
      end
      if ((!s_axis_tvalid_i || s_axis_tready_o) && cmd_pending.size() > 0) begin
        // after a pop the head is the next item
        if ($urandom_range(0, 99) >= src_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {3'b0, cmd_pending[0].qv, cmd_pending[0].cb,
                              cmd_pending[0].owner, cmd_pending[0].delay,
                              cmd_pending[0].slot};
          s_axis_tuser_i  <= cmd_pending[0].kind;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end else if (s_axis_tvalid_i && s_axis_tready_o) begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver ready, with one long hold-off counted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_off_cycles <= 0;
      hold_off_done   <= 1'b0;
    end else if (hold_off_req && !hold_off_done) begin
      hold_off_done   <= 1'b1;
      hold_off_cycles <= 199;
      m_axis_tready_i <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t got;
    res_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind    = rkind_e'(m_axis_tuser_o);
      got.slot    = m_axis_tdata_o[3:0];
      got.owner   = m_axis_tdata_o[11:4];
      got.wake    = m_axis_tdata_o[12];
      got.sw      = m_axis_tdata_o[13];
      got.reached = m_axis_tdata_o[14];
      got.last    = m_axis_tlast_o;
      if (res_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: %p", got);
      end else begin
        exp_r = res_expected.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p actual %p", exp_r, got);
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    @(posedge clk_i);
    while (s_axis_tvalid_i) @(posedge clk_i);
    wait (res_expected.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && res_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
